### src/sha256_pkg.sv
// Shared constants, types and round functions of the SHA-256 engine.
package sha256_pkg;

  localparam int unsigned LengthBitsDefault = 64;
  localparam int unsigned QueueDepthDefault = 4;

  // Front-to-back queue entry: one 32-bit block word plus block markers.
  typedef struct packed {
    logic [31:0] data;
    logic        block_end;  // Sixteenth word of a block.
    logic        msg_end;    // Block end that also finishes the message.
  } blk_word_t;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

### src/sha256_if.sv
// Valid/ready channel interfaces for message input and digest output.
interface sha256_msg_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  valid_bytes;
  logic        last_word;
  modport source (output valid, message_word, valid_bytes, last_word, input ready);
  modport sink (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface sha256_dig_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_last;
  modport source (output valid, digest_word, word_index, digest_last, input ready);
  modport sink (input valid, digest_word, word_index, digest_last, output ready);
endinterface

### src/sha256_front.sv
// Front end: accepts message items, counts length and emits padded block words.
module sha256_front #(
  parameter int unsigned LENGTH_BITS = sha256_pkg::LengthBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  sha256_msg_if.sink            msg,
  output logic                  q_valid,
  input  logic                  q_ready,
  output sha256_pkg::blk_word_t q_word
);

  typedef enum logic [1:0] {ST_TAKE, ST_PADBYTE, ST_ZEROS, ST_LENGTH} state_t;

  state_t                 state;
  logic [3:0]             word_position;
  logic [LENGTH_BITS-1:0] bit_length;
  logic                   len_low;  // Second length word pending.
  logic [63:0]            len64;

  logic [2:0]  nvalid;
  logic [31:0] keep;
  logic [31:0] pad_word;
  logic [5:0]  add_bits;
  logic [LENGTH_BITS-1:0] bit_length_next;

  assign len64 = 64'(bit_length);

  // Clamp the byte count and build the masked last word with its pad byte.
  always_comb begin
    nvalid = (msg.valid_bytes > 3'd4) ? 3'd4 : msg.valid_bytes;
    unique case (nvalid)
      3'd0:    keep = 32'h0000_0000;
      3'd1:    keep = 32'hff00_0000;
      3'd2:    keep = 32'hffff_0000;
      3'd3:    keep = 32'hffff_ff00;
      default: keep = 32'hffff_ffff;
    endcase
    unique case (nvalid)
      3'd0:    pad_word = {sha256_pkg::PadByte, 24'h0};
      3'd1:    pad_word = {8'h0, sha256_pkg::PadByte, 16'h0};
      3'd2:    pad_word = {16'h0, sha256_pkg::PadByte, 8'h0};
      default: pad_word = {24'h0, sha256_pkg::PadByte};
    endcase
    add_bits = msg.last_word ? {nvalid, 3'b000} : 6'd32;
    bit_length_next = bit_length + LENGTH_BITS'(add_bits);
  end

  // Word sent into the queue in the current state.
  always_comb begin
    q_word = '0;
    q_valid = 1'b0;
    msg.ready = 1'b0;
    unique case (state)
      ST_TAKE: begin
        q_valid = msg.valid;
        msg.ready = q_ready;
        q_word.data = (msg.last_word && nvalid != 3'd4) ?
                      ((msg.message_word & keep) | pad_word) : msg.message_word;
      end
      ST_PADBYTE: begin
        q_valid = 1'b1;
        q_word.data = {sha256_pkg::PadByte, 24'h0};
      end
      ST_ZEROS: begin
        q_valid = 1'b1;
        q_word.data = '0;
      end
      ST_LENGTH: begin
        q_valid = 1'b1;
        q_word.data = len_low ? len64[31:0] : len64[63:32];
        q_word.msg_end = len_low;
      end
      default: ;
    endcase
    q_word.block_end = (word_position == 4'd15);
  end

  // Sequencer over message words, pad byte, zero fill and length.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_TAKE;
      word_position <= '0;
      bit_length <= '0;
      len_low <= 1'b0;
    end else if (q_valid && q_ready) begin
      word_position <= word_position + 4'd1;
      unique case (state)
        ST_TAKE: begin
          bit_length <= bit_length_next;
          if (msg.last_word) begin
            if (nvalid == 3'd4) state <= ST_PADBYTE;
            else if (word_position == 4'd13) state <= ST_LENGTH;
            else state <= ST_ZEROS;
          end
        end
        ST_PADBYTE: state <= (word_position == 4'd13) ? ST_LENGTH : ST_ZEROS;
        ST_ZEROS:   if (word_position == 4'd13) state <= ST_LENGTH;
        ST_LENGTH: begin
          len_low <= ~len_low;
          if (len_low) begin
            state <= ST_TAKE;
            bit_length <= '0;
          end
        end
        default: state <= ST_TAKE;
      endcase
    end
  end

endmodule

### src/sha256_queue.sv
// Small FIFO that decouples the padding front end from the compression core.
module sha256_queue #(
  parameter int unsigned DEPTH = sha256_pkg::QueueDepthDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sha256_pkg::blk_word_t in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sha256_pkg::blk_word_t out_word
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sha256_pkg::blk_word_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != (AW+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign out_word  = slots[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  // Storage writes need no reset.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_word;
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

### src/sha256_core.sv
// Back end: gathers block words, runs 64 rounds, updates and emits the hash.
module sha256_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  sha256_pkg::blk_word_t q_word,
  sha256_dig_if.source          dig
);

  typedef enum logic [1:0] {ST_LOAD, ST_ROUND, ST_UPDATE, ST_EMIT} state_t;

  state_t      state;
  logic [31:0] hash_value [8];
  logic [31:0] wv [8];
  logic [31:0] win [16];   // Message words, then the rolling schedule.
  logic [5:0]  round_count;
  logic        msg_end;
  logic [2:0]  out_idx;

  logic [31:0] w_t;
  logic [31:0] t1;
  logic [31:0] t2;

  assign q_ready = (state == ST_LOAD);
  assign dig.valid = (state == ST_EMIT);
  assign dig.digest_word = hash_value[out_idx];
  assign dig.word_index = out_idx;
  assign dig.digest_last = (out_idx == 3'd7);

  // One round: schedule word from the window and the compression step.
  always_comb begin
    w_t = (round_count < 6'd16) ? win[0] :
          sha256_pkg::small_sigma1(win[14]) + win[9] +
          sha256_pkg::small_sigma0(win[1]) + win[0];
    t1 = wv[7] + sha256_pkg::big_sigma1(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) +
         sha256_pkg::RoundK[round_count] + w_t;
    t2 = sha256_pkg::big_sigma0(wv[0]) +
         ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  end

  // Sequencer: load sixteen words, run rounds, fold in, emit on message end.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      round_count <= '0;
      out_idx <= '0;
      msg_end <= 1'b0;
      for (int i = 0; i < 8; i++) hash_value[i] <= sha256_pkg::InitHash[i];
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (q_valid) begin
            for (int i = 0; i < 15; i++) win[i] <= win[i+1];
            win[15] <= q_word.data;
            if (q_word.block_end) begin
              state <= ST_ROUND;
              msg_end <= q_word.msg_end;
              round_count <= '0;
              for (int i = 0; i < 8; i++) wv[i] <= hash_value[i];
            end
          end
        end
        ST_ROUND: begin
          for (int i = 0; i < 15; i++) win[i] <= win[i+1];
          win[15] <= w_t;
          wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4];
          wv[4] <= wv[3] + t1;
          wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0];
          wv[0] <= t1 + t2;
          round_count <= round_count + 6'd1;
          if (round_count == 6'd63) state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          for (int i = 0; i < 8; i++) hash_value[i] <= hash_value[i] + wv[i];
          out_idx <= '0;
          state <= msg_end ? ST_EMIT : ST_LOAD;
        end
        ST_EMIT: begin
          if (dig.ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              state <= ST_LOAD;
              for (int i = 0; i < 8; i++) hash_value[i] <= sha256_pkg::InitHash[i];
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

### src/sha256_hash_engine_core.sv
// Top level of the SHA-256 engine: padding front end, queue and round core.
// Usage:
//   msg channel: one item per 32-bit big-endian message word; valid_bytes
//   (0..4) counts leading valid bytes and matters only on the item with
//   last_word set. Counts above four act as four.
//   dig channel: after the last word, eight items carry the digest words
//   in order, index 0 first, digest_last on the eighth.
// Timing: the round core loads a block of sixteen words, runs 64 rounds
//   (one round per cycle) and then folds in the hash in ST_UPDATE; it
//   takes no new block words until that is done.
//   The front end pads (up to 18 extra words) while the core is busy, and
//   the four-entry queue between them lets each side stall on its own.
// Order: dig.valid rises after the last padding word enters the core,
//   the 64 rounds run and the hash is folded in.
// Reset: synchronous, active high; clears the length count, restores the
//   initial hash and empties the queue. No clearing pass is needed.
// Stall: while dig.ready is low the current digest word holds; the queue
//   and front end then fill and msg.ready drops.
module sha256_hash_engine_core #(
  parameter int unsigned LENGTH_BITS = sha256_pkg::LengthBitsDefault
) (
  input logic          clk,
  input logic          rst,
  sha256_msg_if.sink   msg,
  sha256_dig_if.source dig
);

  logic                  f_valid;
  logic                  f_ready;
  sha256_pkg::blk_word_t f_word;
  logic                  b_valid;
  logic                  b_ready;
  sha256_pkg::blk_word_t b_word;

  sha256_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk(clk), .rst(rst), .msg(msg),
    .q_valid(f_valid), .q_ready(f_ready), .q_word(f_word)
  );

  sha256_queue #(.DEPTH(sha256_pkg::QueueDepthDefault)) u_queue (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_word(f_word),
    .out_valid(b_valid), .out_ready(b_ready), .out_word(b_word)
  );

  sha256_core u_core (
    .clk(clk), .rst(rst),
    .q_valid(b_valid), .q_ready(b_ready), .q_word(b_word), .dig(dig)
  );

endmodule

### src/sha256_checker.sv
// Port-level checker for the SHA-256 engine and its bind statement.
module sha256_checker (
  input logic        clk,
  input logic        rst,
  input logic        dig_valid,
  input logic        dig_ready,
  input logic [31:0] dig_word,
  input logic [2:0]  dig_index,
  input logic        dig_last
);

  // The last flag marks exactly index seven.
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> (dig_last == (dig_index == 3'd7)))
    else $error("digest_last does not match word_index");

  // Indices advance by one after each taken word inside a digest.
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && dig_ready && !dig_last) |=> (dig_valid && dig_index == $past(dig_index) + 3'd1))
    else $error("digest words not contiguous");

  // A stalled digest item keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && !dig_ready) |=> (dig_valid && $stable(dig_word) && $stable(dig_index)))
    else $error("digest item changed while stalled");

  // Nothing is emitted right after reset.
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !dig_valid)
    else $error("digest valid right after reset");

endmodule

bind sha256_hash_engine_core sha256_checker u_checker (
  .clk(clk), .rst(rst),
  .dig_valid(dig.valid), .dig_ready(dig.ready), .dig_word(dig.digest_word),
  .dig_index(dig.word_index), .dig_last(dig.digest_last)
);

### bench/sha256_hash_engine_core_tb.sv
// Testbench for the SHA-256 engine: directed and random messages against a local hash model.
module sha256_hash_engine_core_tb;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
  } msg_item_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  logic clk;
  logic rst;
  int   errors;
  int   msg_idle_pct;
  int   dig_idle_pct;
  int   hold_cycles;
  bit   stim_done;

  msg_item_t    pending_words[$];
  digest_item_t expected_digest[$];

  // Hash state of the local model.
  logic [31:0] hash_h[8];
  logic [31:0] block_w[16];
  logic [63:0] length_bits;
  int          block_fill;

  sha256_msg_if msg (clk);
  sha256_dig_if dig (clk);

  sha256_hash_engine_core i_dut (
    .clk (clk),
    .rst (rst),
    .msg (msg),
    .dig (dig)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One full 64-round compression of the gathered block.
  task automatic compress_gathered();
    logic [31:0] sched[64];
    logic [31:0] v[8];
    logic [31:0] t1;
    logic [31:0] t2;
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        sched[t] = block_w[t];
      end else begin
        sched[t] = (ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10))
                 + sched[t-7]
                 + (ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3))
                 + sched[t-16];
      end
    end
    for (int i = 0; i < 8; i++) v[i] = hash_h[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundK[t] + sched[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] += v[i];
  endtask

  task automatic append_word(logic [31:0] w);
    block_w[block_fill] = w;
    block_fill++;
    if (block_fill == 16) begin
      compress_gathered();
      block_fill = 0;
    end
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_h[i] = sha256_pkg::InitHash[i];
    length_bits = '0;
    block_fill  = 0;
  endtask

  // Advance the model by one accepted message item.
  task automatic hash_accepted_word(msg_item_t it);
    int          n;
    logic [31:0] keep;
    digest_item_t d;
    n = (it.nbytes > 4) ? 4 : it.nbytes;
    if (!it.last) begin
      length_bits += 64'd32;
      append_word(it.word);
      return;
    end
    length_bits += 64'(8 * n);
    if (n == 4) begin
      append_word(it.word);
      append_word(32'h8000_0000);
    end else begin
      keep = (n == 0) ? 32'h0 : (32'hffff_ffff << (8 * (4 - n)));
      append_word((it.word & keep) | (32'(sha256_pkg::PadByte) << (8 * (3 - n))));
    end
    if (block_fill > 14) begin
      while (block_fill != 0) append_word(32'h0);
    end
    while (block_fill < 14) append_word(32'h0);
    append_word(length_bits[63:32]);
    append_word(length_bits[31:0]);
    for (int i = 0; i < 8; i++) begin
      d.word  = hash_h[i];
      d.index = 3'(i);
      d.last  = (i == 7);
      expected_digest.push_back(d);
    end
    restart_hash();
  endtask

  task automatic queue_word(logic [31:0] w, logic [2:0] nb, logic last);
    msg_item_t it;
    it.word = w; it.nbytes = nb; it.last = last;
    pending_words.push_back(it);
  endtask

  // A message of nwords full words followed by a last word with tail bytes.
  task automatic queue_message(int nwords, logic [2:0] tail);
    for (int i = 0; i < nwords; i++) begin
      queue_word($urandom, (($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4),
                 1'b0);
    end
    queue_word($urandom, tail, 1'b1);
  endtask

  // Driver: offers queued items with random idle cycles.
  always @(posedge clk) begin
    if (rst) begin
      msg.valid        <= 1'b0;
      msg.message_word <= '0;
      msg.valid_bytes  <= '0;
      msg.last_word    <= 1'b0;
    end else if (!msg.valid || msg.ready) begin
      if (msg.valid && msg.ready) hash_accepted_word(pending_words.pop_front());
      if (pending_words.size() != 0 && $urandom_range(99, 0) >= msg_idle_pct) begin
        msg.valid        <= 1'b1;
        msg.message_word <= pending_words[0].word;
        msg.valid_bytes  <= pending_words[0].nbytes;
        msg.last_word    <= pending_words[0].last;
      end else begin
        msg.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted digest item and randomizes ready.
  always @(posedge clk) begin
    digest_item_t e;
    if (rst) begin
      dig.ready <= 1'b0;
    end else begin
      if (dig.valid && dig.ready) begin
        if (expected_digest.size() == 0) begin
          $display("%0t: unexpected digest item %h idx %0d", $time, dig.digest_word,
                   dig.word_index);
          errors++;
        end else begin
          e = expected_digest.pop_front();
          if (dig.digest_word !== e.word || dig.word_index !== e.index ||
              dig.digest_last !== e.last) begin
            $display("%0t: digest mismatch expected %h/%0d/%0b actual %h/%0d/%0b", $time,
                     e.word, e.index, e.last, dig.digest_word, dig.word_index,
                     dig.digest_last);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        dig.ready <= 1'b0;
      end else begin
        dig.ready <= ($urandom_range(99, 0) >= dig_idle_pct);
      end
    end
  end

  initial begin
    int lens[6];
    rst = 1'b1;
    errors = 0;
    stim_done = 1'b0;
    hold_cycles = 0;
    msg_idle_pct = 14;
    dig_idle_pct = 82;
    restart_hash();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty message, tail sizes, oversize counts, padding spill lengths.
    queue_word(32'h0, 3'd0, 1'b1);
    queue_word(32'hffff_ffff, 3'd1, 1'b1);
    queue_word(32'h6162_6300, 3'd3, 1'b1);
    queue_word(32'hffff_ffff, 3'd7, 1'b1);
    queue_word(32'hffff_ffff, 3'd5, 1'b0);
    queue_word(32'h1234_5678, 3'd2, 1'b1);
    queue_message(13, 3'd4);
    queue_message(14, 3'd0);
    queue_message(15, 3'd3);

    // Random messages, phase one.
    while (pending_words.size() < 52) begin
      queue_message($urandom_range(0, 17), 3'($urandom_range(0, 7)));
    end
    wait (pending_words.size() == 0 && expected_digest.size() == 0);

    // Phase two: swap idling and stall the receiver for a long stretch.
    msg_idle_pct = 82;
    dig_idle_pct = 14;
    hold_cycles = 400;
    lens = '{1, 15, 16, 17, 2, 0};
    foreach (lens[i]) queue_message(lens[i], 3'($urandom_range(0, 4)));
    msg_idle_pct = 0;
    while (pending_words.size() < 40) begin
      queue_message($urandom_range(0, 17), 3'($urandom_range(0, 7)));
    end
    wait (hold_cycles == 0);
    msg_idle_pct = 82;
    wait (pending_words.size() == 0 && expected_digest.size() == 0);

    // Phase three: no idling.
    msg_idle_pct = 0;
    dig_idle_pct = 0;
    while (pending_words.size() < 10) begin
      queue_message($urandom_range(0, 17), 3'($urandom_range(0, 7)));
    end
    wait (pending_words.size() == 0 && expected_digest.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
src/sha256_pkg.sv
src/sha256_if.sv
src/sha256_front.sv
src/sha256_queue.sv
src/sha256_core.sv
src/sha256_hash_engine_core.sv
src/sha256_checker.sv
bench/sha256_hash_engine_core_tb.sv
